// ----- rtl/core/rlmsd_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and codes of the led matrix scan driver
package rlmsd_pkg;

  // panel geometry
  localparam int PANEL_HEIGHT = 32;
  localparam int PANEL_WIDTH  = 64;
  localparam int HALF_ROWS    = PANEL_HEIGHT / 2;
  localparam int HALF_DEPTH   = HALF_ROWS * PANEL_WIDTH;
  localparam int ADDR_W       = $clog2(HALF_DEPTH);
  localparam int ROW_W        = $clog2(HALF_ROWS);
  localparam int COL_W        = $clog2(PANEL_WIDTH);

  // field widths
  localparam int COORD_W    = 8;
  localparam int LEVEL_W    = 8;
  localparam int DEPTH_W    = 4;
  localparam int PLANE_W    = 8;
  localparam int LIMIT_W    = PLANE_W + 1;
  localparam int ROW_ADDR_W = 4;

  // colour depth register
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;
  localparam int                 REG_PLANE_BITS = 0;

  // item kinds and result events
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;
  localparam logic EVT_SHIFT  = 1'b0;
  localparam logic EVT_LATCH  = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } pixel_t;

  // classified item passed from front to back
  typedef struct packed {
    logic              tick;
    logic              lower;
    logic [ADDR_W-1:0] addr;
    pixel_t            pixel;
  } item_t;

  typedef struct packed {
    logic                  event_res;
    logic                  upper_red;
    logic                  upper_green;
    logic                  upper_blue;
    logic                  lower_red;
    logic                  lower_green;
    logic                  lower_blue;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  last;
  } result_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic clearing;
  } back_status_t;

endpackage

// ----- rtl/core/rlmsd_front.sv -----
`timescale 1ns / 1ps
// front end: accepts transactions, drops off-panel writes, maps pixels to a half and address
module rlmsd_front (
  input  logic                           start,
  input  logic                           kind,
  input  logic [rlmsd_pkg::COORD_W-1:0]  pixel_row,
  input  logic [rlmsd_pkg::COORD_W-1:0]  pixel_col,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]  red_level,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]  green_level,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]  blue_level,
  input  rlmsd_pkg::back_status_t        status,
  output logic                           busy,
  output logic                           push,
  output rlmsd_pkg::item_t               item
);
  import rlmsd_pkg::*;

  logic             accept;
  logic             in_panel;
  logic             lower;
  logic [ROW_W-1:0] row_local;

  assign busy   = status.full | status.clearing;
  assign accept = start & ~busy;

  // panel bounds check, widened so that any panel size compares correctly
  assign in_panel = ({1'b0, pixel_row} < 9'(PANEL_HEIGHT)) &&
                    ({1'b0, pixel_col} < 9'(PANEL_WIDTH));

  // rows of the lower half live in their own store
  assign lower     = {1'b0, pixel_row} >= 9'(HALF_ROWS);
  assign row_local = lower ? ROW_W'(pixel_row - COORD_W'(HALF_ROWS)) : ROW_W'(pixel_row);

  // ticks always go through, writes only when on the panel
  assign push = accept & ((kind == KIND_TICK) | in_panel);

  always_comb begin
    item.tick        = (kind == KIND_TICK);
    item.lower       = lower;
    item.addr        = ADDR_W'(int'(row_local) * PANEL_WIDTH + int'(pixel_col));
    item.pixel.red   = red_level;
    item.pixel.green = green_level;
    item.pixel.blue  = blue_level;
  end

endmodule

// ----- rtl/core/rlmsd_queue.sv -----
`timescale 1ns / 1ps
// two-entry queue between front and back ends
module rlmsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlmsd_pkg::item_t  push_item,
  input  logic              pop,
  output logic              not_empty,
  output logic              full,
  output rlmsd_pkg::item_t  head
);
  import rlmsd_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ----- rtl/core/rlmsd_back.sv -----
`timescale 1ns / 1ps
// back end: frame store, scan counters and result generation
module rlmsd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rlmsd_pkg::DEPTH_W-1:0]  plane_bits,
  input  logic                           item_valid,
  input  rlmsd_pkg::item_t               item,
  output logic                           pop,
  output logic                           clearing,
  output logic                           done,
  output rlmsd_pkg::result_t             result
);
  import rlmsd_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } back_state_t;

  back_state_t state;
  logic [ADDR_W-1:0] clr_addr;

  // frame store, one memory per panel half
  pixel_t mem_up [HALF_DEPTH];
  pixel_t mem_lo [HALF_DEPTH];
  pixel_t rd_up;
  pixel_t rd_lo;

  logic              we_up;
  logic              we_lo;
  logic [ADDR_W-1:0] wr_addr;
  pixel_t            wr_data;
  logic [ADDR_W-1:0] rd_addr;

  // scan counters
  logic [COL_W-1:0]   column_count;
  logic [ROW_W-1:0]   scan_row;
  logic [PLANE_W-1:0] plane_count;

  // result stages
  logic               s1_valid;
  logic               s1_wrap;
  logic [PLANE_W-1:0] s1_k;
  logic [ROW_W-1:0]   s1_row;
  logic               lat_valid;
  logic [ROW_ADDR_W-1:0] lat_row;

  logic                 pop_tick;
  logic                 col_wrap;
  logic                 row_wrap;
  logic [DEPTH_W-1:0]   depth_eff;
  logic [LIMIT_W-1:0]   plane_limit;
  logic [LIMIT_W-1:0]   plane_inc;

  assign clearing = (state == ST_CLEAR);

  // a row-end tick owns the next result slot, so the queue is held while its shift result is out
  assign pop      = item_valid & (state == ST_RUN) & ~(s1_valid & s1_wrap);
  assign pop_tick = pop & item.tick;

  // clearing pass after reset, one address of both halves a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(HALF_DEPTH - 1)) state <= ST_RUN;
        end
        ST_RUN:   state <= ST_RUN;
        default:  state <= ST_CLEAR;
      endcase
    end
  end

  // write port select
  always_comb begin
    if (clearing) begin
      wr_addr = clr_addr;
      wr_data = '0;
      we_up   = 1'b1;
      we_lo   = 1'b1;
    end else begin
      wr_addr = item.addr;
      wr_data = item.pixel;
      we_up   = pop & ~item.tick & ~item.lower;
      we_lo   = pop & ~item.tick &  item.lower;
    end
  end

  assign rd_addr = ADDR_W'(int'(scan_row) * PANEL_WIDTH + int'(column_count));

  // memories with registered read
  always_ff @(posedge clk) begin
    if (we_up) mem_up[wr_addr] <= wr_data;
    if (we_lo) mem_lo[wr_addr] <= wr_data;
    rd_up <= mem_up[rd_addr];
    rd_lo <= mem_lo[rd_addr];
  end

  // plane limit from the clamped colour depth
  always_comb begin
    if (plane_bits < DEPTH_MIN)      depth_eff = DEPTH_MIN;
    else if (plane_bits > DEPTH_MAX) depth_eff = DEPTH_MAX;
    else                             depth_eff = plane_bits;
    plane_limit = LIMIT_W'(1) << depth_eff;
    plane_inc   = {1'b0, plane_count} + LIMIT_W'(1);
  end

  assign col_wrap = (column_count == COL_W'(PANEL_WIDTH - 1));
  assign row_wrap = (scan_row == ROW_W'(HALF_ROWS - 1));

  // column advances on each tick, row on a column wrap, plane on a row wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      scan_row     <= '0;
      plane_count  <= '0;
    end else if (pop_tick) begin
      if (col_wrap) begin
        column_count <= '0;
        if (row_wrap) begin
          scan_row <= '0;
          if (plane_inc >= plane_limit) plane_count <= '0;
          else                          plane_count <= plane_inc[PLANE_W-1:0];
        end else begin
          scan_row <= scan_row + ROW_W'(1);
        end
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // shift stage and latch stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      lat_valid <= 1'b0;
    end else begin
      s1_valid  <= pop_tick;
      lat_valid <= s1_valid & s1_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_tick) begin
      s1_wrap <= col_wrap;
      s1_k    <= plane_count;
      s1_row  <= scan_row;
    end
    lat_row <= ROW_ADDR_W'(s1_row);
  end

  // result drive
  assign done = s1_valid | lat_valid;

  always_comb begin
    result.event_res   = lat_valid ? EVT_LATCH : EVT_SHIFT;
    result.upper_red   = s1_valid & (rd_up.red   > s1_k);
    result.upper_green = s1_valid & (rd_up.green > s1_k);
    result.upper_blue  = s1_valid & (rd_up.blue  > s1_k);
    result.lower_red   = s1_valid & (rd_lo.red   > s1_k);
    result.lower_green = s1_valid & (rd_lo.green > s1_k);
    result.lower_blue  = s1_valid & (rd_lo.blue  > s1_k);
    result.row_address = lat_valid ? lat_row : '0;
    result.last        = lat_valid | (s1_valid & ~s1_wrap);
  end

  // shift and latch results never share a cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && lat_valid))
    else $error("shift and latch results overlap");

  // every row-end shift is followed by a latch
  a_latch_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_wrap) |=> lat_valid)
    else $error("latch missing after row end");

  // a latch only comes from a row-end shift
  a_latch_cause: assert property (@(posedge clk) disable iff (rst)
    lat_valid |-> $past(s1_valid && s1_wrap))
    else $error("latch without row end");

  // nothing leaves the queue while the store is being cleared
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("item taken during clearing pass");

endmodule

// ----- rtl/core/rgb_led_matrix_scan_driver_core.sv -----
`timescale 1ns / 1ps
// top level of the led matrix scan driver: configuration port and block wiring
// After reset the frame store is cleared, one address of each panel half per cycle, which
// keeps busy high until all 1024 addresses are cleared; configuration writes are taken
// during that time. A transaction is taken when start is high and busy is low, one per
// cycle, and a two-entry queue decouples this from the back end. The back end works one
// transaction a cycle unless it holds the queue; a tick's shift result is on the ports in
// the cycle after the tick leaves the queue, and the tick that ends a row adds the latch
// result in the following cycle. While the row-end shift result is out the back end takes
// nothing from the queue. Writes give no result.
// Results are valid for one cycle with done high and cannot be stalled.
module rgb_led_matrix_scan_driver_core (
  input  logic                           clk,
  input  logic                           rst,
  // transaction port
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [rlmsd_pkg::COORD_W-1:0]  pixel_row,
  input  logic [rlmsd_pkg::COORD_W-1:0]  pixel_col,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]  red_level,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]  green_level,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]  blue_level,
  // result port
  output logic                           done,
  output logic                           event_res,
  output logic                           upper_red,
  output logic                           upper_green,
  output logic                           upper_blue,
  output logic                           lower_red,
  output logic                           lower_green,
  output logic                           lower_blue,
  output logic [rlmsd_pkg::ROW_ADDR_W-1:0] row_address,
  output logic                           last,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rlmsd_pkg::*;

  logic [DEPTH_W-1:0] plane_bits;
  back_status_t       status;
  logic               push;
  item_t              push_item;
  logic               pop;
  logic               not_empty;
  logic               full;
  logic               clearing;
  item_t              head;
  result_t            result;

  // colour depth register, the only register: every address writes it, only address 0 reads it
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_bits <= DEPTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      plane_bits <= pwdata[DEPTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'(4 * REG_PLANE_BITS)) prdata[DEPTH_W-1:0] = plane_bits;
  end

  assign status.full     = full;
  assign status.clearing = clearing;

  rlmsd_front u_front (
    .start       (start),
    .kind        (kind),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .status      (status),
    .busy        (busy),
    .push        (push),
    .item        (push_item)
  );

  rlmsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (not_empty),
    .full      (full),
    .head      (head)
  );

  rlmsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .plane_bits  (plane_bits),
    .item_valid  (not_empty),
    .item        (head),
    .pop         (pop),
    .clearing    (clearing),
    .done        (done),
    .result      (result)
  );

  // result fields to ports
  assign event_res   = result.event_res;
  assign upper_red   = result.upper_red;
  assign upper_green = result.upper_green;
  assign upper_blue  = result.upper_blue;
  assign lower_red   = result.lower_red;
  assign lower_green = result.lower_green;
  assign lower_blue  = result.lower_blue;
  assign row_address = result.row_address;
  assign last        = result.last;

endmodule

// ----- bench/scan_driver_checker.sv -----
`timescale 1ns / 1ps
// checker for the led matrix scan driver: tracks the frame store, predicts and compares events
module scan_driver_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             kind,
  input  logic [rlmsd_pkg::COORD_W-1:0]    pixel_row,
  input  logic [rlmsd_pkg::COORD_W-1:0]    pixel_col,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]    red_level,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]    green_level,
  input  logic [rlmsd_pkg::LEVEL_W-1:0]    blue_level,
  input  logic                             done,
  input  logic                             event_res,
  input  logic                             upper_red,
  input  logic                             upper_green,
  input  logic                             upper_blue,
  input  logic                             lower_red,
  input  logic                             lower_green,
  input  logic                             lower_blue,
  input  logic [rlmsd_pkg::ROW_ADDR_W-1:0] row_address,
  input  logic                             last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [1:0]                       paddr,
  input  logic [31:0]                      pwdata,
  input  logic [31:0]                      prdata,
  input  logic                             pready,
  output int                               mismatches,
  output int                               outstanding
);
  import rlmsd_pkg::*;

  localparam int         PIXELS     = PANEL_HEIGHT * PANEL_WIDTH;
  localparam logic [1:0] DEPTH_ADDR = 2'(4 * REG_PLANE_BITS);

  // own copy of the frame store and scan position
  logic [LEVEL_W-1:0] stored_red   [PIXELS];
  logic [LEVEL_W-1:0] stored_green [PIXELS];
  logic [LEVEL_W-1:0] stored_blue  [PIXELS];
  int                 scan_col;
  int                 scan_row;
  int                 plane;
  logic [DEPTH_W-1:0] depth_reg;
  result_t            pending_events[$];
  result_t            seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // next scan events for one tick: a column shift, and the latch at the end of a row
  task automatic predict_scan_tick();
    int                 up;
    int                 lo;
    logic [DEPTH_W-1:0] eff_depth;
    result_t            shift_ev;
    result_t            latch_ev;
    up = scan_row * PANEL_WIDTH + scan_col;
    lo = up + HALF_ROWS * PANEL_WIDTH;
    shift_ev.event_res   = EVT_SHIFT;
    shift_ev.upper_red   = stored_red[up] > plane;
    shift_ev.upper_green = stored_green[up] > plane;
    shift_ev.upper_blue  = stored_blue[up] > plane;
    shift_ev.lower_red   = stored_red[lo] > plane;
    shift_ev.lower_green = stored_green[lo] > plane;
    shift_ev.lower_blue  = stored_blue[lo] > plane;
    shift_ev.row_address = '0;
    scan_col++;
    shift_ev.last = (scan_col != PANEL_WIDTH);
    pending_events.push_back(shift_ev);
    if (scan_col == PANEL_WIDTH) begin
      latch_ev             = '0;
      latch_ev.event_res   = EVT_LATCH;
      latch_ev.row_address = ROW_ADDR_W'(scan_row);
      latch_ev.last        = 1'b1;
      pending_events.push_back(latch_ev);
      scan_col = 0;
      scan_row++;
      // rows first, then the brightness plane, clamped depth
      if (scan_row == HALF_ROWS) begin
        scan_row  = 0;
        plane++;
        eff_depth = depth_reg;
        if (eff_depth < DEPTH_MIN) eff_depth = DEPTH_MIN;
        if (eff_depth > DEPTH_MAX) eff_depth = DEPTH_MAX;
        if (plane >= (1 << eff_depth)) plane = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIXELS; i++) begin
        stored_red[i]   = '0;
        stored_green[i] = '0;
        stored_blue[i]  = '0;
      end
      scan_col  = 0;
      scan_row  = 0;
      plane     = 0;
      depth_reg = DEPTH_RESET;
      pending_events.delete();
      mismatches = 0;
    end else begin
      // configuration port access
      if (psel && penable && pready && paddr == DEPTH_ADDR) begin
        if (pwrite) depth_reg = pwdata[DEPTH_W-1:0];
        else if (prdata !== {{(32 - DEPTH_W){1'b0}}, depth_reg})
          report_mismatch("depth register readback", prdata, 32'(depth_reg));
      end
      // accepted transaction
      if (start && !busy) begin
        if (kind == KIND_WRITE) begin
          if (pixel_row < PANEL_HEIGHT && pixel_col < PANEL_WIDTH) begin
            stored_red[pixel_row * PANEL_WIDTH + pixel_col]   = red_level;
            stored_green[pixel_row * PANEL_WIDTH + pixel_col] = green_level;
            stored_blue[pixel_row * PANEL_WIDTH + pixel_col]  = blue_level;
          end
        end else begin
          predict_scan_tick();
        end
      end
      // result against the oldest pending event
      if (done) begin
        if (pending_events.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd1, 32'd0);
        end else begin
          seen = pending_events.pop_front();
          if (event_res !== seen.event_res)
            report_mismatch("event_res", 32'(event_res), 32'(seen.event_res));
          if (upper_red !== seen.upper_red)
            report_mismatch("upper_red", 32'(upper_red), 32'(seen.upper_red));
          if (upper_green !== seen.upper_green)
            report_mismatch("upper_green", 32'(upper_green), 32'(seen.upper_green));
          if (upper_blue !== seen.upper_blue)
            report_mismatch("upper_blue", 32'(upper_blue), 32'(seen.upper_blue));
          if (lower_red !== seen.lower_red)
            report_mismatch("lower_red", 32'(lower_red), 32'(seen.lower_red));
          if (lower_green !== seen.lower_green)
            report_mismatch("lower_green", 32'(lower_green), 32'(seen.lower_green));
          if (lower_blue !== seen.lower_blue)
            report_mismatch("lower_blue", 32'(lower_blue), 32'(seen.lower_blue));
          if (row_address !== seen.row_address)
            report_mismatch("row_address", 32'(row_address), 32'(seen.row_address));
          if (last !== seen.last)
            report_mismatch("last", 32'(last), 32'(seen.last));
        end
      end
    end
    outstanding = pending_events.size();
  end

endmodule

// ----- bench/rgb_led_matrix_scan_driver_core_test.sv -----
`timescale 1ns / 1ps
// testbench top of the led matrix scan driver: clock, reset, stimulus and verdict
module rgb_led_matrix_scan_driver_core_test;
  import rlmsd_pkg::*;

  localparam logic [1:0] DEPTH_ADDR    = 2'(4 * REG_PLANE_BITS);
  localparam int         SETTLE_CYCLES = 12;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PHASE_ITEMS   = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  kind;
  logic [COORD_W-1:0]    pixel_row;
  logic [COORD_W-1:0]    pixel_col;
  logic [LEVEL_W-1:0]    red_level;
  logic [LEVEL_W-1:0]    green_level;
  logic [LEVEL_W-1:0]    blue_level;
  logic                  done;
  logic                  event_res;
  logic                  upper_red;
  logic                  upper_green;
  logic                  upper_blue;
  logic                  lower_red;
  logic                  lower_green;
  logic                  lower_blue;
  logic [ROW_ADDR_W-1:0] row_address;
  logic                  last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [1:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;
  int                    idle_pct;

  always #5 clk = ~clk;

  rgb_led_matrix_scan_driver_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .done        (done),
    .event_res   (event_res),
    .upper_red   (upper_red),
    .upper_green (upper_green),
    .upper_blue  (upper_blue),
    .lower_red   (lower_red),
    .lower_green (lower_green),
    .lower_blue  (lower_blue),
    .row_address (row_address),
    .last        (last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  scan_driver_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .done        (done),
    .event_res   (event_res),
    .upper_red   (upper_red),
    .upper_green (upper_green),
    .upper_blue  (upper_blue),
    .lower_red   (lower_red),
    .lower_green (lower_green),
    .lower_blue  (lower_blue),
    .row_address (row_address),
    .last        (last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // level biased towards the low planes half the time
  function automatic logic [LEVEL_W-1:0] pick_level();
    return $urandom_range(1) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(3));
  endfunction

  // one transaction; entered and left at a falling edge with start still high
  task automatic drive_item(input logic k, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c, input logic [LEVEL_W-1:0] rl,
                            input logic [LEVEL_W-1:0] gl, input logic [LEVEL_W-1:0] bl);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    kind        <= k;
    pixel_row   <= r;
    pixel_col   <= c;
    red_level   <= rl;
    green_level <= gl;
    blue_level  <= bl;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // write the depth register, then read it back
  task automatic set_color_bits(input logic [DEPTH_W-1:0] depth);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= DEPTH_ADDR;
    pwdata  <= {28'($urandom), depth};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic               k;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [DEPTH_W-1:0] d;
    int                 taken;
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_WRITE;
    pixel_row   = '0;
    pixel_col   = '0;
    red_level   = '0;
    green_level = '0;
    blue_level  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_pct    = 14;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // above the top depth, acts as eight
    set_color_bits(4'd15);

    // directed: corners of both halves, level extremes, writes off the panel
    drive_item(KIND_WRITE, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1);
    drive_item(KIND_WRITE, 8'd16, 8'd0, 8'd0, 8'd255, 8'd0);
    drive_item(KIND_WRITE, 8'd0, 8'd1, 8'd1, 8'd1, 8'd255);
    drive_item(KIND_WRITE, 8'd16, 8'd1, 8'd255, 8'd255, 8'd255);
    drive_item(KIND_WRITE, 8'd31, 8'd63, 8'd255, 8'd1, 8'd0);
    drive_item(KIND_WRITE, 8'd15, 8'd63, 8'd0, 8'd0, 8'd255);
    drive_item(KIND_WRITE, 8'd32, 8'd0, 8'd255, 8'd255, 8'd255);
    drive_item(KIND_WRITE, 8'd0, 8'd64, 8'd255, 8'd255, 8'd255);
    drive_item(KIND_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    drive_item(KIND_WRITE, 8'd18, 8'd2, 8'd255, 8'd255, 8'd255);
    drive_item(KIND_WRITE, 8'd18, 8'd2, 8'd0, 8'd0, 8'd0);
    drive_item(KIND_WRITE, 8'd2, 8'd2, 8'd128, 8'd64, 8'd2);
    repeat (4) drive_item(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // random phases, each under its own depth; the first runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      start <= 1'b0;
      while (outstanding != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (ph)
        0:       d = DEPTH_MAX;
        1:       d = 4'd2;
        2:       d = DEPTH_MIN;
        default: d = 4'd0;
      endcase
      set_color_bits(d);
      idle_pct = (ph == 0) ? 0 : 14;
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        if ($urandom_range(99) < 90) begin
          k = KIND_TICK;
          r = COORD_W'($urandom);
          c = COORD_W'($urandom);
        end else begin
          k = KIND_WRITE;
          if ($urandom_range(99) < 85) begin
            r = COORD_W'($urandom_range(PANEL_HEIGHT - 1));
            c = COORD_W'($urandom_range(PANEL_WIDTH - 1));
          end else begin
            r = COORD_W'($urandom);
            c = COORD_W'($urandom);
          end
        end
        drive_item(k, r, c, pick_level(), pick_level(), pick_level());
        if (k == KIND_TICK || (r < PANEL_HEIGHT && c < PANEL_WIDTH)) taken++;
      end
    end

    // drain and verdict
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
